// ===== rtl/dswc_pkg.sv =====
// Package with the shared widths, types and constants of the dice sum way counter.
`timescale 1ns / 1ps

package dswc_pkg;

   localparam int DICE_W  = 6;
   localparam int FACES_W = 6;
   localparam int TGT_W   = 11;
   localparam int WAY_W   = 30;

   typedef logic [DICE_W-1:0]  dice_type;
   typedef logic [FACES_W-1:0] faces_type;
   typedef logic [TGT_W-1:0]   target_type;
   typedef logic [WAY_W-1:0]   way_type;

   // Modulus of all way counts.
   localparam way_type WAY_MOD = 30'd1000000007;

endpackage

// ===== rtl/dswc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module dswc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dice_sum_way_counter.sv =====
// Top level of the dice sum way counter: sequencer, modular datapath and row memories.
// A request with a target above MAX_TARGET or with zero dice strobes its result in the
// cycle after acceptance; any other request strobes it after the S_GAP state of its last die.
// One request is worked on at a time; per die there is a single pass over row entries
// 0..target_sum, one entry per cycle, followed by an S_GAP state for the pipeline to drain.
// The receiver cannot stall, so there is no back pressure. Synchronous reset returns the
// sequencer to idle; memories are not cleared.
`timescale 1ns / 1ps

module dice_sum_way_counter #(
   parameter int MAX_TARGET = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dswc_pkg::dice_type   req_num_dice,
   input  dswc_pkg::faces_type  req_faces,
   input  dswc_pkg::target_type req_target_sum,
   output logic                 rsp_valid,
   output dswc_pkg::way_type    rsp_way_count
);

   import dswc_pkg::*;

   // Row depth and address width follow from the largest target.
   localparam int DEPTH = MAX_TARGET + 1;
   localparam int AW    = $clog2(DEPTH);
   // Common width for comparing targets, indexes and face counts.
   localparam int CW    = (AW > TGT_W) ? AW : TGT_W;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_GAP  = 3'b100
   } state_type;

   // Modular add of two reduced values.
   function automatic way_type mod_add(input way_type x, input way_type y);
      logic [WAY_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, WAY_MOD}) begin
         s = s - {1'b0, WAY_MOD};
      end
      return s[WAY_W-1:0];
   endfunction

   // Modular subtract of two reduced values.
   function automatic way_type mod_sub(input way_type x, input way_type y);
      logic [WAY_W:0] d;
      if (x >= y) begin
         d = {1'b0, x} - {1'b0, y};
      end else begin
         d = {1'b0, x} + {1'b0, WAY_MOD} - {1'b0, y};
      end
      return d[WAY_W-1:0];
   endfunction

   // Sequencer state and the parameters of the transaction under way.
   state_type     state_ff, state_in;
   logic [AW-1:0] s_ff, s_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   dice_type      dice_ff, dice_in;
   faces_type     nf_ff, nf_in;
   logic          first_ff, first_in;

   // Read stage: one row entry is in flight between issue and update.
   logic          v1_ff;
   logic [AW-1:0] s1_ff;
   logic          zero1_ff;
   logic          first1_ff;
   logic          lowmem1_ff;
   logic          lowfwd1_ff;

   // Running prefix sum of the old row.
   way_type       p_ff;

   // Result register; the strobe lasts exactly one cycle.
   logic          rsp_valid_ff, rsp_valid_in;
   way_type       rsp_way_ff, rsp_way_in;

   // Memory ports.
   way_type       a_rd;
   way_type       b_rd;
   logic [AW-1:0] b_rd_addr;

   // Lower edge of the face window: entry s - faces - 1 of the prefix row.
   logic [CW:0]   s_x;
   logic [CW:0]   nf_x;
   logic [CW:0]   diff_x;
   logic          low_ok;

   // Update stage.
   way_type       prev;
   way_type       a_val;
   way_type       low_val;
   way_type       p_in;
   way_type       new_val;
   logic          issue;

   assign s_x       = (CW + 1)'(s_ff);
   assign nf_x      = (CW + 1)'(nf_ff) + (CW + 1)'(1);
   assign diff_x    = s_x - nf_x;
   assign low_ok    = (s_x >= nf_x);
   assign b_rd_addr = diff_x[AW-1:0];
   assign issue     = (state_ff == S_RUN);

   // On the first die the row is taken as freshly cleared: one way at sum 0, none elsewhere,
   // so the memory is never swept at the start of a transaction.
   assign prev    = zero1_ff ? '0 : p_ff;
   assign a_val   = first1_ff ? (zero1_ff ? way_type'(1) : '0) : a_rd;
   // With zero faces the window is empty; the lower prefix equals the one just before s,
   // which is still in the prefix register, so it is forwarded instead of read back.
   assign low_val = lowmem1_ff ? b_rd : (lowfwd1_ff ? prev : '0);
   assign p_in    = mod_add(prev, a_val);
   assign new_val = mod_sub(prev, low_val);

   // way_row: read at s for the prefix pass, rewritten in place with the next row.
   dswc_ram #(
      .WIDTH (WAY_W),
      .DEPTH (DEPTH)
   ) u_way_row (
      .clock   (clock),
      .wr_en   (v1_ff),
      .wr_addr (s1_ff),
      .wr_data (new_val),
      .rd_addr (s_ff),
      .rd_data (a_rd)
   );

   // prefix_row: holds the prefix sums of the current die, read back at the window's low edge.
   dswc_ram #(
      .WIDTH (WAY_W),
      .DEPTH (DEPTH)
   ) u_prefix_row (
      .clock   (clock),
      .wr_en   (v1_ff),
      .wr_addr (s1_ff),
      .wr_data (p_in),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd)
   );

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      tgt_in       = tgt_ff;
      dice_in      = dice_ff;
      nf_in        = nf_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_way_in   = rsp_way_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (CW'(req_target_sum) > CW'(MAX_TARGET)) begin
                  // The row cannot hold this target: no ways.
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = '0;
               end else if (req_num_dice == '0) begin
                  // No dice: one way only for a zero target.
                  rsp_valid_in = 1'b1;
                  rsp_way_in   = (req_target_sum == '0) ? way_type'(1) : '0;
               end else begin
                  state_in = S_RUN;
                  s_in     = '0;
                  tgt_in   = AW'(req_target_sum);
                  dice_in  = req_num_dice;
                  nf_in    = req_faces;
                  first_in = 1'b1;
               end
            end
         end
         S_RUN: begin
            if (s_ff == tgt_ff) begin
               state_in = S_GAP;
            end else begin
               s_in = s_ff + AW'(1);
            end
         end
         S_GAP: begin
            // The last entry of this die is updated in this cycle.
            first_in = 1'b0;
            dice_in  = dice_ff - DICE_W'(1);
            s_in     = '0;
            if (dice_ff == DICE_W'(1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_way_in   = new_val;
            end else begin
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      tgt_ff      <= tgt_in;
      dice_ff     <= dice_in;
      nf_ff       <= nf_in;
      first_ff    <= first_in;
      rsp_way_ff  <= rsp_way_in;
      s1_ff       <= s_ff;
      zero1_ff    <= (s_ff == '0);
      first1_ff   <= first_ff;
      lowmem1_ff  <= low_ok && (nf_ff != '0);
      lowfwd1_ff  <= low_ok && (nf_ff == '0);
      if (v1_ff) begin
         p_ff <= p_in;
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_way_count = rsp_way_ff;

   // A result is always a reduced residue.
   a_rsp_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_way_count < WAY_MOD))
      else $error("way count not reduced");

   // An accepted transaction either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction dropped");

   // The scan index never passes the target while entries are issued.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (s_ff <= tgt_ff))
      else $error("row index beyond target");

   // Nothing is left in flight once the sequencer is idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !v1_ff)
      else $error("row update in flight while idle");

   // The final result is strobed only as the last die drains.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(state_ff == S_GAP)) |-> (state_ff == S_IDLE))
      else $error("result strobed with dice left");

endmodule
